>>> rtl/core/lrpc_pkg.sv
// ----------------------------------------------------------------------------
// lrpc_pkg: shared types and constants of the log ring
// Ring geometry, chunk limits, function codes and the beat formats of the
// request and result ports.
// ----------------------------------------------------------------------------
package lrpc_pkg;

  // Ring and chunk geometry. The ring depth is a power of two.
  localparam int unsigned RING_DEPTH  = 1024;
  localparam int unsigned CHUNK_MAX   = 512;
  localparam int unsigned PACKET_SIZE = 64;

  // Derived widths. Pointers carry one extra wrap bit over the index.
  localparam int unsigned IDX_W  = $clog2(RING_DEPTH);
  localparam int unsigned PTR_W  = IDX_W + 1;
  localparam int unsigned CLEN_W = 10;
  localparam int unsigned LEN_W  = 16;
  localparam int unsigned DATA_W = 8;
  localparam int unsigned CNT_W  = 32;

  // Function codes of a request beat.
  typedef enum logic [1:0] {
    FUNC_RESERVE = 2'd0,
    FUNC_DATA    = 2'd1,
    FUNC_CHUNK   = 2'd2,
    FUNC_DONE    = 2'd3
  } lrpc_func_e;

  // Request beat.
  typedef struct packed {
    lrpc_func_e         func;
    logic [LEN_W-1:0]   msg_len;
    logic [DATA_W-1:0]  data_byte;
    logic [IDX_W-1:0]   read_offset;
    logic               read_only;
    logic               link_ready;
  } lrpc_req_t;

  // Result beat.
  typedef struct packed {
    logic               status;
    logic [IDX_W-1:0]   chunk_start;
    logic [CLEN_W-1:0]  chunk_len;
    logic [DATA_W-1:0]  read_data;
    logic [CNT_W-1:0]   dropped_total;
    logic [PTR_W-1:0]   used_count;
  } lrpc_rsp_t;

  // Access to the ring memory for one request.
  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [DATA_W-1:0]  wdata;
    logic               re;
    logic [IDX_W-1:0]   raddr;
  } lrpc_mem_req_t;

endpackage

>>> rtl/core/lrpc_ram.sv
// ----------------------------------------------------------------------------
// lrpc_ram: generic single-clock RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module lrpc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/lrpc_ctrl.sv
// ----------------------------------------------------------------------------
// lrpc_ctrl: pointer and chunk control of the log ring
// Updates the head, tail and write pointers, the reservation count, the
// granted chunk and the dropped total for each request beat, and registers
// the result fields apart from the read byte.
// ----------------------------------------------------------------------------
module lrpc_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  lrpc_pkg::lrpc_req_t    req_i,
  output lrpc_pkg::lrpc_mem_req_t mem_o,
  output logic                   valid_o,
  output logic                   read_sel_o,
  output lrpc_pkg::lrpc_rsp_t    rsp_o
);

  import lrpc_pkg::*;

  logic [PTR_W-1:0]  head_q, head_d;
  logic [PTR_W-1:0]  tail_q, tail_d;
  logic [PTR_W-1:0]  wptr_q, wptr_d;
  logic [LEN_W-1:0]  remain_q, remain_d;
  logic [CLEN_W-1:0] grant_q, grant_d;
  logic [CNT_W-1:0]  dropped_q, dropped_d;

  logic              valid_q;
  logic              read_sel_q, read_sel_d;
  lrpc_rsp_t         rsp_q, rsp_d;

  logic [PTR_W-1:0]  used;
  logic [PTR_W-1:0]  free_bytes;
  logic [IDX_W-1:0]  rd_idx;
  logic [PTR_W-1:0]  run_wrap;
  logic [PTR_W-1:0]  run_used;
  logic [PTR_W-1:0]  run_cap;
  logic [PTR_W-1:0]  run_pkt;

  // Occupancy and the contiguous run that starts at the tail.
  always_comb begin
    used       = head_q - tail_q;
    free_bytes = PTR_W'(RING_DEPTH) - used;
    rd_idx     = tail_q[IDX_W-1:0];
    run_wrap   = PTR_W'(RING_DEPTH) - {1'b0, rd_idx};
    run_used   = (run_wrap > used) ? used : run_wrap;
    run_cap    = (run_used > PTR_W'(CHUNK_MAX)) ? PTR_W'(CHUNK_MAX) : run_used;
    run_pkt    = (run_cap > PTR_W'(PACKET_SIZE)) ?
                 (run_cap & ~PTR_W'(PACKET_SIZE - 1)) : run_cap;
  end

  // Next state, memory access and result fields for one request beat.
  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    wptr_d     = wptr_q;
    remain_d   = remain_q;
    grant_d    = grant_q;
    dropped_d  = dropped_q;
    read_sel_d = 1'b0;
    rsp_d      = '0;

    mem_o       = '0;
    mem_o.waddr = wptr_q[IDX_W-1:0];
    mem_o.wdata = req_i.data_byte;
    mem_o.raddr = req_i.read_offset;

    if (accept_i) begin
      case (req_i.func)
        FUNC_RESERVE: begin
          if (req_i.msg_len > LEN_W'(free_bytes)) begin
            dropped_d    = dropped_q + CNT_W'(req_i.msg_len);
            remain_d     = '0;
            rsp_d.status = 1'b1;
          end else begin
            wptr_d   = head_q;
            remain_d = req_i.msg_len;
            head_d   = head_q + PTR_W'(req_i.msg_len);
          end
        end
        FUNC_DATA: begin
          if (remain_q != '0) begin
            mem_o.we = 1'b1;
            wptr_d   = wptr_q + PTR_W'(1);
            remain_d = remain_q - LEN_W'(1);
          end else begin
            rsp_d.status = 1'b1;
          end
        end
        FUNC_CHUNK: begin
          if (used == '0 || !req_i.link_ready) begin
            grant_d      = '0;
            rsp_d.status = 1'b1;
          end else begin
            grant_d           = CLEN_W'(run_pkt);
            rsp_d.chunk_start = rd_idx;
            rsp_d.chunk_len   = CLEN_W'(run_pkt);
          end
        end
        FUNC_DONE: begin
          mem_o.re   = 1'b1;
          read_sel_d = 1'b1;
          if (!req_i.read_only) begin
            if (grant_q != '0) begin
              tail_d  = tail_q + PTR_W'(grant_q);
              grant_d = '0;
            end else begin
              rsp_d.status = 1'b1;
            end
          end
        end
        default: begin
          rsp_d.status = 1'b1;
        end
      endcase
    end

    rsp_d.dropped_total = dropped_d;
    rsp_d.used_count    = head_d - tail_d;
  end

  // Ring state and the result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      tail_q    <= '0;
      wptr_q    <= '0;
      remain_q  <= '0;
      grant_q   <= '0;
      dropped_q <= '0;
      valid_q   <= 1'b0;
    end else begin
      head_q    <= head_d;
      tail_q    <= tail_d;
      wptr_q    <= wptr_d;
      remain_q  <= remain_d;
      grant_q   <= grant_d;
      dropped_q <= dropped_d;
      valid_q   <= accept_i;
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      rsp_q      <= rsp_d;
      read_sel_q <= read_sel_d;
    end
  end

  assign valid_o    = valid_q;
  assign read_sel_o = read_sel_q;
  assign rsp_o      = rsp_q;

endmodule

>>> rtl/core/log_ring_with_packet_chunks_top.sv
// ----------------------------------------------------------------------------
// log_ring_with_packet_chunks_top: byte ring for log messages
// Reserves space for whole messages, fills it byte by byte, grants chunks
// from the tail in whole packets (if over one packet) and reads back stored bytes.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                    Handshake
//   --------  -----------------------  ---------------------------------------
//   request   start, busy, req_i       beat taken when start is high, busy low
//   result    valid_o, result_o        one-cycle strobe, receiver cannot stall
//
// Every request beat gives one result beat in the cycle after it is
// taken; a new beat is taken every cycle, so busy is always low.
// The read byte comes from the registered read port of the ring memory.
// Reset clears the pointers, the granted chunk and the dropped total; the
// ring memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module log_ring_with_packet_chunks_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  lrpc_pkg::lrpc_req_t req_i,
  output logic                valid_o,
  output lrpc_pkg::lrpc_rsp_t result_o
);

  import lrpc_pkg::*;

  logic          accept;
  lrpc_mem_req_t mem_req;
  logic [DATA_W-1:0] ram_rdata;
  logic          read_sel;
  lrpc_rsp_t     ctrl_rsp;

  // The block takes a beat in every cycle.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  lrpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .req_i      (req_i),
    .mem_o      (mem_req),
    .valid_o    (valid_o),
    .read_sel_o (read_sel),
    .rsp_o      (ctrl_rsp)
  );

  lrpc_ram #(
    .Width (DATA_W),
    .Depth (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (ram_rdata)
  );

  // Merge the read byte into the result of a read item.
  always_comb begin
    result_o           = ctrl_rsp;
    result_o.read_data = read_sel ? ram_rdata : '0;
  end

endmodule
